@@ rtl/pbdc_pkg.sv @@
// ----------------------------------------------------------------------------
// pbdc_pkg
// Shared types, register map and gain table of the PCM bit-depth converter.
// ----------------------------------------------------------------------------
package pbdc_pkg;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [ADDR_W-1:0] ADDR_IN_DEPTH  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_OUT_DEPTH = 3'd4;

    localparam logic [1:0] DEPTH_8  = 2'd0;
    localparam logic [1:0] DEPTH_16 = 2'd1;
    localparam logic [1:0] DEPTH_24 = 2'd2;
    localparam logic [1:0] DEPTH_32 = 2'd3;

    localparam logic [1:0] DEPTH_RESET = DEPTH_16;

    localparam logic [63:0] FS_8  = 64'd255;
    localparam logic [63:0] FS_16 = 64'd32767;
    localparam logic [63:0] FS_24 = 64'd8388607;
    localparam logic [63:0] FS_32 = 64'd2147483520;

    localparam logic [55:0] CLAMP_8  = 56'd255;
    localparam logic [55:0] CLAMP_16 = 56'd32767;
    localparam logic [55:0] CLAMP_24 = 56'd8388607;

    // gain = round(fs_out / fs_in) in Q24.32, row = input depth, column = output depth
    localparam logic [63:0] GAIN_TBL [4][4] = '{
        '{((FS_8  << 32) + (FS_8  >> 1)) / FS_8,
          ((FS_16 << 32) + (FS_8  >> 1)) / FS_8,
          ((FS_24 << 32) + (FS_8  >> 1)) / FS_8,
          ((FS_32 << 32) + (FS_8  >> 1)) / FS_8},
        '{((FS_8  << 32) + (FS_16 >> 1)) / FS_16,
          ((FS_16 << 32) + (FS_16 >> 1)) / FS_16,
          ((FS_24 << 32) + (FS_16 >> 1)) / FS_16,
          ((FS_32 << 32) + (FS_16 >> 1)) / FS_16},
        '{((FS_8  << 32) + (FS_24 >> 1)) / FS_24,
          ((FS_16 << 32) + (FS_24 >> 1)) / FS_24,
          ((FS_24 << 32) + (FS_24 >> 1)) / FS_24,
          ((FS_32 << 32) + (FS_24 >> 1)) / FS_24},
        '{((FS_8  << 32) + (FS_32 >> 1)) / FS_32,
          ((FS_16 << 32) + (FS_32 >> 1)) / FS_32,
          ((FS_24 << 32) + (FS_32 >> 1)) / FS_32,
          ((FS_32 << 32) + (FS_32 >> 1)) / FS_32}
    };

    typedef struct packed {
        logic [1:0] in_depth;
        logic [1:0] out_depth;
        logic       clr;
    } t_cfg;

    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
    } t_smp;

    function automatic logic [55:0] gain_of(input logic [1:0] din, input logic [1:0] dout);
        logic [63:0] g;
        g = GAIN_TBL[din][dout];
        return g[55:0];
    endfunction

endpackage

@@ rtl/pbdc_cfg.sv @@
// ----------------------------------------------------------------------------
// pbdc_cfg
// APB register file holding the input and output sample depths.
// ----------------------------------------------------------------------------
module pbdc_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbdc_pkg::ADDR_W-1:0] paddr,
    input  logic [pbdc_pkg::DATA_W-1:0] pwdata,
    output logic [pbdc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output pbdc_pkg::t_cfg              o_cfg
);
    import pbdc_pkg::*;

    logic [1:0] r_in_depth;
    logic [1:0] r_out_depth;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_depth  <= DEPTH_RESET;
            r_out_depth <= DEPTH_RESET;
        end else if (wr_en) begin
            case (paddr)
                ADDR_IN_DEPTH:  r_in_depth  <= pwdata[1:0];
                ADDR_OUT_DEPTH: r_out_depth <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_IN_DEPTH:  prdata = {30'd0, r_in_depth};
            ADDR_OUT_DEPTH: prdata = {30'd0, r_out_depth};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.in_depth  = r_in_depth;
    assign o_cfg.out_depth = r_out_depth;
    assign o_cfg.clr       = wr_en && (paddr == ADDR_IN_DEPTH);

endmodule

@@ rtl/pbdc_assemble.sv @@
// ----------------------------------------------------------------------------
// pbdc_assemble
// Gathers little-endian bytes into one sample and registers its sign and
// magnitude.
// ----------------------------------------------------------------------------
module pbdc_assemble (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pbdc_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    output logic           o_valid,
    input  logic           i_ready,
    output pbdc_pkg::t_smp o_smp
);
    import pbdc_pkg::*;

    logic [23:0] r_partial;
    logic [1:0]  r_count;
    logic        r_v1;
    t_smp        r_smp;

    logic        complete;
    logic        rdy1;
    logic        accept;
    logic [31:0] merged;
    logic [31:0] raw;
    t_smp        n_smp;

    assign complete = (r_count >= i_cfg.in_depth);
    assign rdy1     = !r_v1 || i_ready;
    assign o_ready  = !complete || rdy1;
    assign accept   = i_valid && o_ready;
    assign merged   = {8'd0, r_partial} | ({24'd0, i_byte} << {r_count, 3'b000});

    always_comb begin
        raw       = merged;
        n_smp.neg = 1'b0;
        n_smp.mag = merged;
        case (i_cfg.in_depth)
            DEPTH_8: begin
                raw       = {24'd0, merged[7:0]};
                n_smp.mag = raw;
            end
            DEPTH_16: begin
                raw       = {16'd0, merged[15:0]};
                n_smp.neg = raw[15];
                n_smp.mag = raw[15] ? (32'h0001_0000 - raw) : raw;
            end
            DEPTH_24: begin
                raw       = {8'd0, merged[23:0]};
                n_smp.neg = raw[23];
                n_smp.mag = raw[23] ? (32'h0100_0000 - raw) : raw;
            end
            default: begin
                raw       = merged;
                n_smp.neg = raw[31];
                n_smp.mag = raw[31] ? (32'd0 - raw) : raw;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_count   <= '0;
            r_v1      <= 1'b0;
        end else begin
            if (i_cfg.clr) begin
                r_partial <= '0;
                r_count   <= '0;
            end else if (accept) begin
                if (complete) begin
                    r_partial <= '0;
                    r_count   <= '0;
                end else begin
                    r_partial <= merged[23:0];
                    r_count   <= r_count + 2'd1;
                end
            end
            if (rdy1) begin
                r_v1 <= accept && complete;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_smp <= n_smp;
        end
    end

    assign o_valid = r_v1;
    assign o_smp   = r_smp;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= i_cfg.in_depth)
        else $error("byte count beyond input depth");

    a_sample_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !i_ready) |=> (r_v1 && $stable(r_smp)))
        else $error("pending sample lost");

endmodule

@@ rtl/pbdc_scale.sv @@
// ----------------------------------------------------------------------------
// pbdc_scale
// Multiplies the sample magnitude by the Q24.32 gain, then truncates,
// limits to the output width and restores the sign except for 8 bit.
// ----------------------------------------------------------------------------
module pbdc_scale (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pbdc_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  pbdc_pkg::t_smp i_smp,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_val
);
    import pbdc_pkg::*;

    logic        r_v2;
    logic        r_neg;
    logic [55:0] r_p_hi;
    logic [31:0] r_p_lo;

    logic        rdy2;
    logic [55:0] gain;
    logic [63:0] prod_lo;
    logic [55:0] scaled;
    logic [55:0] lim;

    assign rdy2    = !r_v2 || i_ready;
    assign o_ready = rdy2;
    assign gain    = gain_of(i_cfg.in_depth, i_cfg.out_depth);
    assign prod_lo = i_smp.mag * gain[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_neg  <= i_smp.neg;
            r_p_hi <= i_smp.mag * gain[55:32];
            r_p_lo <= prod_lo[63:32];
        end
    end

    assign scaled = r_p_hi + {24'd0, r_p_lo};

    always_comb begin
        lim   = scaled;
        o_val = scaled[31:0];
        case (i_cfg.out_depth)
            DEPTH_8: begin
                lim   = (scaled > CLAMP_8) ? CLAMP_8 : scaled;
                o_val = lim[31:0];
            end
            DEPTH_16: begin
                lim   = (scaled > CLAMP_16) ? CLAMP_16 : scaled;
                o_val = r_neg ? (32'd0 - lim[31:0]) : lim[31:0];
            end
            DEPTH_24: begin
                lim   = (scaled > CLAMP_24) ? CLAMP_24 : scaled;
                o_val = r_neg ? (32'd0 - lim[31:0]) : lim[31:0];
            end
            default: begin
                lim   = scaled;
                o_val = r_neg ? (32'd0 - scaled[31:0]) : scaled[31:0];
            end
        endcase
    end

    assign o_valid = r_v2;

endmodule

@@ rtl/pbdc_serialize.sv @@
// ----------------------------------------------------------------------------
// pbdc_serialize
// Holds one converted sample and sends it out one byte per transaction,
// least significant byte first.
// ----------------------------------------------------------------------------
module pbdc_serialize (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pbdc_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [31:0]    i_val,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_byte,
    output logic           o_last
);
    import pbdc_pkg::*;

    logic        r_sv;
    logic [31:0] r_val;
    logic [1:0]  r_idx;
    logic [1:0]  r_last_idx;

    logic        rdy3;
    logic        load;
    logic        take;

    assign o_last  = (r_idx == r_last_idx);
    assign take    = r_sv && i_ready;
    assign rdy3    = !r_sv || (i_ready && o_last);
    assign o_ready = rdy3;
    assign load    = i_valid && rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= 1'b0;
            r_idx <= '0;
        end else if (load) begin
            r_sv  <= 1'b1;
            r_idx <= '0;
        end else if (take) begin
            if (o_last) begin
                r_sv <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_val      <= i_val;
            r_last_idx <= i_cfg.out_depth;
        end
    end

    assign o_valid = r_sv;
    assign o_byte  = r_val[{r_idx, 3'b000} +: 8];

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> (r_idx <= r_last_idx))
        else $error("byte index beyond sample width");

    a_mid_sample_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !o_last) |=> (r_sv && (r_idx == $past(r_idx) + 2'd1)))
        else $error("sample cut short");

endmodule

@@ rtl/pcm_bit_depth_converter_core.sv @@
// ----------------------------------------------------------------------------
// pcm_bit_depth_converter_core
// Converts a little-endian PCM byte stream between 8, 16, 24 and 32 bit depths.
// ----------------------------------------------------------------------------
// The slave stream carries input bytes; the master stream carries output
// bytes with tlast on the final byte of each converted sample. The APB port
// sets in_depth (0x0) and out_depth (0x4); write them only while idle.
// Writing in_depth drops any partly gathered sample.
// A byte that completes a sample passes the assemble, scale and serialize
// registers on its way to the master stream. Input bytes are taken one
// per cycle while s_axis_tready is high; each sample leaves as out_depth+1
// bytes, and the serializer loads the next sample only as its last byte is
// taken. Up to two finished samples wait in the assemble and scale registers
// while the serializer drains one, so the input keeps flowing during a stall
// until those registers fill; then s_axis_tready drops on a completing byte.
// Reset sets both depths to 16 bit and empties the pipeline.
// ----------------------------------------------------------------------------
module pcm_bit_depth_converter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbdc_pkg::ADDR_W-1:0] paddr,
    input  logic [pbdc_pkg::DATA_W-1:0] pwdata,
    output logic [pbdc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] in_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [7:0] out_byte
    output logic                        m_axis_tlast    // sample_end
);
    import pbdc_pkg::*;

    t_cfg        cfg;
    t_smp        smp;
    logic        smp_valid;
    logic        smp_ready;
    logic        val_valid;
    logic        val_ready;
    logic [31:0] val;

    pbdc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pbdc_assemble u_assemble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .o_valid (smp_valid),
        .i_ready (smp_ready),
        .o_smp   (smp)
    );

    pbdc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (smp_valid),
        .o_ready (smp_ready),
        .i_smp   (smp),
        .o_valid (val_valid),
        .i_ready (val_ready),
        .o_val   (val)
    );

    pbdc_serialize u_serialize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (val_valid),
        .o_ready (val_ready),
        .i_val   (val),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule
